@@ hdl/lav_pkg.sv @@
// ---------------------------------------------------------------------------
// lav_pkg
// shared constants and types of the look-at view matrix block
// ---------------------------------------------------------------------------
`default_nettype none

package lav_pkg;

   // unit vectors are signed q2.30 held in 32 bits
   localparam int UNIT_BITS = 30;
   localparam int UNIT_W    = 32;
   localparam int CROSS_W   = 64;

   localparam logic [1:0] LAST_ROW = 2'd3;

   typedef enum logic [1:0] {
      REG_UP_X = 2'd0,
      REG_UP_Y = 2'd1,
      REG_UP_Z = 2'd2
   } reg_index_type;

endpackage

`default_nettype wire

@@ hdl/lav_norm.sv @@
// ---------------------------------------------------------------------------
// lav_norm
// pipelined vector normaliser: leading-one search, scaling to unsigned q0.30,
// sum of squares, bit-per-stage square root and three restoring dividers
// ---------------------------------------------------------------------------
`default_nettype none

module lav_norm
   import lav_pkg::*;
#(
   parameter int IN_W   = 33,
   parameter int SIDE_W = 1
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                advance,
   input  wire logic                in_valid,
   input  wire logic [3*IN_W-1:0]   in_vec,
   input  wire logic [SIDE_W-1:0]   in_side,
   output logic                     out_valid,
   output logic [3*UNIT_W-1:0]      out_unit,
   output logic                     out_ok,
   output logic [SIDE_W-1:0]        out_side
);

   localparam int NG  = (IN_W + 7) / 8;
   localparam int GW  = (NG > 1) ? $clog2(NG) : 1;
   localparam int LW  = $clog2(IN_W + 1);
   localparam int MW  = UNIT_BITS;
   localparam int RW  = 2 * UNIT_BITS + 4;
   localparam int SQN = UNIT_BITS + 1;
   localparam int QW  = UNIT_BITS + 1;
   localparam int DVN = QW;
   localparam int SW2 = QW + 1;
   localparam int NUMW = 2 * UNIT_BITS + 1;
   localparam int NST = 6 + SQN + 1 + DVN + 1;

   logic [NST-1:0]    vld_ff;
   logic [SIDE_W-1:0] side_ff [NST];

   // stage 0: magnitudes
   logic [IN_W-1:0] mag_in [3];
   logic [2:0]      neg_in;
   logic [IN_W-1:0] mag_a_ff [3];
   logic [2:0]      neg_a_ff;
   // stage 1: leading byte
   logic [NG*8-1:0] or_pad;
   logic [7:0]      byte_in;
   logic [GW-1:0]   grp_in;
   logic [7:0]      byte_b_ff;
   logic [GW-1:0]   grp_b_ff;
   logic [IN_W-1:0] mag_b_ff [3];
   logic [2:0]      neg_b_ff;
   // stage 2: length
   logic [2:0]      pos_in;
   logic [GW+3:0]   len_wide;
   logic [LW-1:0]   len_c_ff;
   logic            zero_c_ff;
   logic [IN_W-1:0] mag_c_ff [3];
   logic [2:0]      neg_c_ff;
   // stage 3: scaling
   logic [IN_W+MW-1:0] wide_in [3];
   logic [MW-1:0]   m_d_ff [3];
   logic [2:0]      neg_d_ff;
   logic            zero_d_ff;
   // stage 4: squares
   logic [2*MW-1:0] sq_e_ff [3];
   logic [MW-1:0]   m_e_ff [3];
   logic [2:0]      neg_e_ff;
   logic            zero_e_ff;
   // square root
   logic [RW-1:0]   x_ff [SQN+1];
   logic [RW-1:0]   r_ff [SQN+1];
   logic [MW-1:0]   sm_ff [SQN+1][3];
   logic [2:0]      sneg_ff [SQN+1];
   logic            szero_ff [SQN+1];
   // division
   logic [NUMW-1:0] num_in [3];
   logic [SW2-1:0]  s_in;
   logic [SW2-1:0]  rem_ff [DVN+1][3];
   logic [QW-1:0]   low_ff [DVN+1][3];
   logic [QW-1:0]   q_ff [DVN+1][3];
   logic [SW2-1:0]  s_ff [DVN+1];
   logic [2:0]      dneg_ff [DVN+1];
   logic            dzero_ff [DVN+1];
   // final
   logic [UNIT_W-1:0] unit_ff [3];
   logic              ok_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[NST-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         side_ff[0] <= in_side;
         for (int i = 1; i < NST; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         neg_in[i] = in_vec[i*IN_W + IN_W - 1];
         mag_in[i] = neg_in[i] ? (~in_vec[i*IN_W +: IN_W] + 1'b1) : in_vec[i*IN_W +: IN_W];
      end
   end

   always_comb begin
      or_pad  = (NG*8)'(mag_a_ff[0] | mag_a_ff[1] | mag_a_ff[2]);
      byte_in = or_pad[7:0];
      grp_in  = '0;
      for (int g = 1; g < NG; g++) begin
         if (|or_pad[g*8 +: 8]) begin
            byte_in = or_pad[g*8 +: 8];
            grp_in  = GW'(g);
         end
      end
   end

   always_comb begin
      pos_in = '0;
      for (int b = 1; b < 8; b++) begin
         if (byte_b_ff[b]) begin
            pos_in = 3'(b);
         end
      end
      len_wide = {1'b0, grp_b_ff, 3'b000} + (GW+4)'(pos_in) + (GW+4)'(1);
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         wide_in[i] = {mag_c_ff[i], MW'(0)} >> len_c_ff;
      end
   end

   always_comb begin
      s_in = r_ff[SQN][SW2-1:0];
      for (int i = 0; i < 3; i++) begin
         num_in[i] = {sm_ff[SQN][i], MW'(0)} + NUMW'(s_in >> 1);
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         mag_a_ff <= mag_in;
         neg_a_ff <= neg_in;

         byte_b_ff <= byte_in;
         grp_b_ff  <= grp_in;
         mag_b_ff  <= mag_a_ff;
         neg_b_ff  <= neg_a_ff;

         len_c_ff  <= LW'(len_wide);
         zero_c_ff <= (byte_b_ff == 8'd0);
         mag_c_ff  <= mag_b_ff;
         neg_c_ff  <= neg_b_ff;

         for (int i = 0; i < 3; i++) begin
            m_d_ff[i] <= wide_in[i][MW-1:0];
         end
         neg_d_ff  <= neg_c_ff;
         zero_d_ff <= zero_c_ff;

         for (int i = 0; i < 3; i++) begin
            sq_e_ff[i] <= m_d_ff[i] * m_d_ff[i];
         end
         m_e_ff    <= m_d_ff;
         neg_e_ff  <= neg_d_ff;
         zero_e_ff <= zero_d_ff;

         x_ff[0]     <= RW'(sq_e_ff[0]) + RW'(sq_e_ff[1]) + RW'(sq_e_ff[2]);
         r_ff[0]     <= '0;
         sm_ff[0]    <= m_e_ff;
         sneg_ff[0]  <= neg_e_ff;
         szero_ff[0] <= zero_e_ff;

         for (int i = 0; i < 3; i++) begin
            rem_ff[0][i] <= SW2'(num_in[i] >> QW);
            low_ff[0][i] <= num_in[i][QW-1:0];
            q_ff[0][i]   <= '0;
         end
         s_ff[0]     <= s_in;
         dneg_ff[0]  <= sneg_ff[SQN];
         dzero_ff[0] <= szero_ff[SQN];

         for (int i = 0; i < 3; i++) begin
            if (dzero_ff[DVN]) begin
               unit_ff[i] <= '0;
            end else if (dneg_ff[DVN][i]) begin
               unit_ff[i] <= -UNIT_W'(q_ff[DVN][i]);
            end else begin
               unit_ff[i] <= UNIT_W'(q_ff[DVN][i]);
            end
         end
         ok_ff <= !dzero_ff[DVN];
      end
   end

   // one root bit per stage
   for (genvar k = 1; k <= SQN; k++) begin : g_sqrt
      localparam logic [RW-1:0] BIT = RW'(1) << (2 * (SQN - k));
      logic [RW-1:0] trial;
      assign trial = r_ff[k-1] + BIT;
      always_ff @(posedge clock) begin
         if (advance) begin
            if (x_ff[k-1] >= trial) begin
               x_ff[k] <= x_ff[k-1] - trial;
               r_ff[k] <= (r_ff[k-1] >> 1) + BIT;
            end else begin
               x_ff[k] <= x_ff[k-1];
               r_ff[k] <= r_ff[k-1] >> 1;
            end
            sm_ff[k]    <= sm_ff[k-1];
            sneg_ff[k]  <= sneg_ff[k-1];
            szero_ff[k] <= szero_ff[k-1];
         end
      end
   end

   // one quotient bit per stage, three lanes
   for (genvar j = 1; j <= DVN; j++) begin : g_div
      for (genvar i = 0; i < 3; i++) begin : g_lane
         logic [SW2:0] part;
         assign part = {rem_ff[j-1][i], low_ff[j-1][i][QW-j]};
         always_ff @(posedge clock) begin
            if (advance) begin
               if (part >= {1'b0, s_ff[j-1]}) begin
                  rem_ff[j][i] <= SW2'(part - {1'b0, s_ff[j-1]});
                  q_ff[j][i]   <= {q_ff[j-1][i][QW-2:0], 1'b1};
               end else begin
                  rem_ff[j][i] <= part[SW2-1:0];
                  q_ff[j][i]   <= {q_ff[j-1][i][QW-2:0], 1'b0};
               end
               low_ff[j][i] <= low_ff[j-1][i];
            end
         end
      end
      always_ff @(posedge clock) begin
         if (advance) begin
            s_ff[j]     <= s_ff[j-1];
            dneg_ff[j]  <= dneg_ff[j-1];
            dzero_ff[j] <= dzero_ff[j-1];
         end
      end
   end

   assign out_valid = vld_ff[NST-1];
   assign out_side  = side_ff[NST-1];
   assign out_ok    = ok_ff;
   assign out_unit  = {unit_ff[2], unit_ff[1], unit_ff[0]};

endmodule

`default_nettype wire

@@ hdl/look_at_view_matrix.sv @@
// ---------------------------------------------------------------------------
// look_at_view_matrix
// look-at camera matrix in signed fixed point, four rows per camera item
// ---------------------------------------------------------------------------
//  channel   role     handshake            content
//  req_*     in       tvalid/tready        position xyz, focus xyz
//  rsp_*     out      tvalid/tready        row index, four columns, tlast, tuser
//  csr_*     config   psel/penable/pready  up vector x, y, z
//
//  an item passes the normalisers and cross products to the result bank;
//  its four rows leave one a cycle while rsp_tready is high; the single
//  result channel sets the item rate; unstalled, the pipeline takes one item a cycle
//  reset clears valid bits and sets the up vector to (0, 1.0, 0)
//  a stall at the result side holds the whole pipeline once its last stage
//  is full; nothing is lost or repeated
// ---------------------------------------------------------------------------
`default_nettype none

module look_at_view_matrix
   import lav_pkg::*;
#(
   parameter int DATA_WIDTH = 32,
   parameter int FRAC_BITS  = 16,
   localparam int CSR_DW = (DATA_WIDTH > 32) ? 64 : 32,
   localparam int CSR_AS = (DATA_WIDTH > 32) ? 3 : 2,
   localparam int CSR_AW = CSR_AS + 2,
   localparam int REQ_W  = ((6 * DATA_WIDTH + 7) / 8) * 8,
   localparam int RSP_W  = ((2 + 4 * DATA_WIDTH + 7) / 8) * 8
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   // position_x, position_y, position_z, focus_x, focus_y, focus_z
   input  wire logic [REQ_W-1:0]  req_tdata,
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   // row_index, col_0, col_1, col_2, col_3
   output logic [RSP_W-1:0]       rsp_tdata,
   output logic                   rsp_tlast,
   // degenerate
   output logic                   rsp_tuser,
   input  wire logic              csr_psel,
   input  wire logic              csr_penable,
   input  wire logic              csr_pwrite,
   input  wire logic [CSR_AW-1:0] csr_paddr,
   input  wire logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0]      csr_prdata,
   output logic                   csr_pready
);

   localparam int DW = DATA_WIDTH;
   localparam int SW = DW + 40;
   localparam int PW = UNIT_W + DW;
   localparam int LS = (FRAC_BITS >= UNIT_BITS) ? FRAC_BITS - UNIT_BITS : 0;
   localparam int RS = (FRAC_BITS >= UNIT_BITS) ? 0 : UNIT_BITS - FRAC_BITS;
   localparam logic signed [SW-1:0] MAX_S = $signed((SW'(1) << (DW - 1)) - SW'(1));
   localparam logic signed [SW-1:0] MIN_S = -MAX_S - SW'(1);
   localparam logic [DW-1:0] ONE_V = (FRAC_BITS >= DW - 1) ? MAX_S[DW-1:0] :
                                                            (DW'(1) << FRAC_BITS);
   localparam int VW = 3 * UNIT_W;
   localparam int U_SIDE = 1 + VW + 3 * DW;
   localparam int V_SIDE = 1 + 2 * VW + 3 * DW;

   function automatic logic signed [SW-1:0] rnd_shift(input logic signed [SW-1:0] v,
                                                      input int k);
      logic [SW-1:0] m;
      logic [SW-1:0] h;
      m = v[SW-1] ? (~v + 1'b1) : v;
      h = (k > 0) ? (SW'(1) << (k - 1)) : '0;
      m = (m + h) >> k;
      return v[SW-1] ? -$signed(m) : $signed(m);
   endfunction

   function automatic logic [DW-1:0] sat_dw(input logic signed [SW-1:0] v);
      if (v > MAX_S) begin
         return MAX_S[DW-1:0];
      end else if (v < MIN_S) begin
         return MIN_S[DW-1:0];
      end
      return v[DW-1:0];
   endfunction

   function automatic logic [DW-1:0] unit_out(input logic signed [UNIT_W-1:0] x);
      logic signed [SW-1:0] e;
      e = SW'(x);
      if (FRAC_BITS >= UNIT_BITS) begin
         e = e <<< LS;
      end else begin
         e = rnd_shift(e, RS);
      end
      return sat_dw(e);
   endfunction

   // configuration
   logic [DW-1:0] up_x_ff, up_y_ff, up_z_ff;
   reg_index_type csr_idx;
   logic          csr_wr;

   assign csr_idx    = reg_index_type'(csr_paddr[CSR_AW-1:CSR_AS]);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         up_x_ff <= '0;
         up_y_ff <= DW'(1) << FRAC_BITS;
         up_z_ff <= '0;
      end else if (csr_wr) begin
         case (csr_idx)
            REG_UP_X: up_x_ff <= csr_pwdata[DW-1:0];
            REG_UP_Y: up_y_ff <= csr_pwdata[DW-1:0];
            REG_UP_Z: up_z_ff <= csr_pwdata[DW-1:0];
            default:  ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_UP_X: csr_prdata = CSR_DW'(up_x_ff);
         REG_UP_Y: csr_prdata = CSR_DW'(up_y_ff);
         REG_UP_Z: csr_prdata = CSR_DW'(up_z_ff);
         default:  csr_prdata = '0;
      endcase
   end

   // flow control
   logic advance;
   logic rb_vld_ff;
   logic ser_vld_ff;
   logic [1:0] row_ff;
   logic ser_free;

   assign ser_free   = !ser_vld_ff || (rsp_tready && row_ff == LAST_ROW);
   assign advance    = !rb_vld_ff || ser_free;
   assign req_tready = advance;

   // input stage
   logic                 t0_vld_ff;
   logic [3*(DW+1)-1:0]  d_ff;
   logic [3*DW-1:0]      p_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         t0_vld_ff <= 1'b0;
      end else if (advance) begin
         t0_vld_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < 3; i++) begin
            d_ff[i*(DW+1) +: DW+1] <=
               {req_tdata[i*DW + DW - 1], req_tdata[i*DW +: DW]} -
               {req_tdata[(i+3)*DW + DW - 1], req_tdata[(i+3)*DW +: DW]};
         end
         p_ff <= req_tdata[3*DW-1:0];
      end
   end

   // w and normalised up
   logic          w_vld, w_ok, up_vld, up_ok;
   logic [VW-1:0] w_unit, up_unit;
   logic [2*DW-1:0] w_side;
   logic [DW-1:0]   up_side;

   lav_norm #(.IN_W(DW + 1), .SIDE_W(2 * DW)) u_norm_w (
      .clock(clock), .reset(reset), .advance(advance),
      .in_valid(t0_vld_ff), .in_vec(d_ff), .in_side(p_ff[2*DW-1:0]),
      .out_valid(w_vld), .out_unit(w_unit), .out_ok(w_ok), .out_side(w_side)
   );

   lav_norm #(.IN_W(DW), .SIDE_W(DW)) u_norm_up (
      .clock(clock), .reset(reset), .advance(advance),
      .in_valid(t0_vld_ff), .in_vec({up_z_ff, up_y_ff, up_x_ff}),
      .in_side(p_ff[3*DW-1:2*DW]),
      .out_valid(up_vld), .out_unit(up_unit), .out_ok(up_ok), .out_side(up_side)
   );

   // u = up x w
   logic signed [UNIT_W-1:0] a1_c [3], b1_c [3];
   logic signed [CROSS_W-1:0] pa1_ff [3], pb1_ff [3], c2_ff [3];
   logic c1_vld_ff, c2_vld_ff, c1_ok_ff, c2_ok_ff;
   logic [VW-1:0] c1_w_ff, c2_w_ff;
   logic [3*DW-1:0] c1_p_ff, c2_p_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         a1_c[i] = $signed(up_unit[i*UNIT_W +: UNIT_W]);
         b1_c[i] = $signed(w_unit[i*UNIT_W +: UNIT_W]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c1_vld_ff <= 1'b0;
         c2_vld_ff <= 1'b0;
      end else if (advance) begin
         c1_vld_ff <= w_vld && up_vld;
         c2_vld_ff <= c1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < 3; i++) begin
            pa1_ff[i] <= a1_c[(i+1)%3] * b1_c[(i+2)%3];
            pb1_ff[i] <= a1_c[(i+2)%3] * b1_c[(i+1)%3];
            c2_ff[i]  <= pa1_ff[i] - pb1_ff[i];
         end
         c1_ok_ff <= w_ok && up_ok;
         c1_w_ff  <= w_unit;
         c1_p_ff  <= {up_side, w_side};
         c2_ok_ff <= c1_ok_ff;
         c2_w_ff  <= c1_w_ff;
         c2_p_ff  <= c1_p_ff;
      end
   end

   logic          u_vld, u_ok;
   logic [VW-1:0] u_unit;
   logic [U_SIDE-1:0] u_side;

   lav_norm #(.IN_W(CROSS_W), .SIDE_W(U_SIDE)) u_norm_u (
      .clock(clock), .reset(reset), .advance(advance),
      .in_valid(c2_vld_ff), .in_vec({c2_ff[2], c2_ff[1], c2_ff[0]}),
      .in_side({c2_ok_ff, c2_w_ff, c2_p_ff}),
      .out_valid(u_vld), .out_unit(u_unit), .out_ok(u_ok), .out_side(u_side)
   );

   // v = w x u
   logic signed [UNIT_W-1:0] a2_c [3], b2_c [3];
   logic signed [CROSS_W-1:0] pa2_ff [3], pb2_ff [3], c4_ff [3];
   logic c3_vld_ff, c4_vld_ff, c3_ok_ff, c4_ok_ff;
   logic [VW-1:0] c3_w_ff, c4_w_ff, c3_u_ff, c4_u_ff;
   logic [3*DW-1:0] c3_p_ff, c4_p_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         a2_c[i] = $signed(u_side[3*DW + i*UNIT_W +: UNIT_W]);
         b2_c[i] = $signed(u_unit[i*UNIT_W +: UNIT_W]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c3_vld_ff <= 1'b0;
         c4_vld_ff <= 1'b0;
      end else if (advance) begin
         c3_vld_ff <= u_vld;
         c4_vld_ff <= c3_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < 3; i++) begin
            pa2_ff[i] <= a2_c[(i+1)%3] * b2_c[(i+2)%3];
            pb2_ff[i] <= a2_c[(i+2)%3] * b2_c[(i+1)%3];
            c4_ff[i]  <= pa2_ff[i] - pb2_ff[i];
         end
         c3_ok_ff <= u_side[U_SIDE-1] && u_ok;
         c3_w_ff  <= u_side[3*DW +: VW];
         c3_u_ff  <= u_unit;
         c3_p_ff  <= u_side[3*DW-1:0];
         c4_ok_ff <= c3_ok_ff;
         c4_w_ff  <= c3_w_ff;
         c4_u_ff  <= c3_u_ff;
         c4_p_ff  <= c3_p_ff;
      end
   end

   logic          v_vld, v_ok;
   logic [VW-1:0] v_unit;
   logic [V_SIDE-1:0] v_side;

   lav_norm #(.IN_W(CROSS_W), .SIDE_W(V_SIDE)) u_norm_v (
      .clock(clock), .reset(reset), .advance(advance),
      .in_valid(c4_vld_ff), .in_vec({c4_ff[2], c4_ff[1], c4_ff[0]}),
      .in_side({c4_ok_ff, c4_u_ff, c4_w_ff, c4_p_ff}),
      .out_valid(v_vld), .out_unit(v_unit), .out_ok(v_ok), .out_side(v_side)
   );

   // frame rows: 0 = u, 1 = v, 2 = w
   logic signed [UNIT_W-1:0] fr_c [3][3];
   logic signed [DW-1:0]     p_c [3];
   logic signed [PW-1:0]     pr_ff [3][3];
   logic signed [SW-1:0]     acc_ff [3];
   logic signed [UNIT_W-1:0] d1_fr_ff [3][3], d2_fr_ff [3][3];
   logic d1_vld_ff, d2_vld_ff, d1_ok_ff, d2_ok_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         fr_c[0][i] = $signed(v_side[3*DW + VW + i*UNIT_W +: UNIT_W]);
         fr_c[1][i] = $signed(v_unit[i*UNIT_W +: UNIT_W]);
         fr_c[2][i] = $signed(v_side[3*DW + i*UNIT_W +: UNIT_W]);
         p_c[i]     = $signed(v_side[i*DW +: DW]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d1_vld_ff <= 1'b0;
         d2_vld_ff <= 1'b0;
         rb_vld_ff <= 1'b0;
      end else if (advance) begin
         d1_vld_ff <= v_vld;
         d2_vld_ff <= d1_vld_ff;
         rb_vld_ff <= d2_vld_ff;
      end
   end

   logic [DW-1:0] rb_ff [4][4];
   logic          rb_deg_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int k = 0; k < 3; k++) begin
            for (int i = 0; i < 3; i++) begin
               pr_ff[k][i] <= PW'(fr_c[k][i]) * PW'(p_c[i]);
            end
            acc_ff[k] <= -(SW'(pr_ff[k][0]) + SW'(pr_ff[k][1]) + SW'(pr_ff[k][2]));
         end
         d1_fr_ff <= fr_c;
         d1_ok_ff <= v_side[V_SIDE-1] && v_ok;
         d2_fr_ff <= d1_fr_ff;
         d2_ok_ff <= d1_ok_ff;

         for (int i = 0; i < 3; i++) begin
            for (int k = 0; k < 3; k++) begin
               rb_ff[i][k] <= unit_out(d2_fr_ff[k][i]);
            end
            rb_ff[i][3] <= '0;
            rb_ff[3][i] <= sat_dw(rnd_shift(acc_ff[i], UNIT_BITS));
         end
         rb_ff[3][3] <= ONE_V;
         rb_deg_ff   <= !d2_ok_ff;
      end
   end

   // row output
   logic [DW-1:0] ser_ff [4][4];
   logic          ser_deg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ser_vld_ff <= 1'b0;
         row_ff     <= '0;
      end else if (rb_vld_ff && ser_free) begin
         ser_vld_ff <= 1'b1;
         row_ff     <= '0;
      end else if (ser_vld_ff && rsp_tready) begin
         if (row_ff == LAST_ROW) begin
            ser_vld_ff <= 1'b0;
         end
         row_ff <= row_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (rb_vld_ff && ser_free) begin
         ser_ff     <= rb_ff;
         ser_deg_ff <= rb_deg_ff;
      end
   end

   assign rsp_tvalid = ser_vld_ff;
   assign rsp_tdata  = RSP_W'({ser_ff[row_ff][3], ser_ff[row_ff][2],
                               ser_ff[row_ff][1], ser_ff[row_ff][0], row_ff});
   assign rsp_tlast  = (row_ff == LAST_ROW);
   assign rsp_tuser  = ser_deg_ff;

endmodule

`default_nettype wire

@@ verif/look_at_view_matrix_tb.sv @@
// ---------------------------------------------------------------------------
// look_at_view_matrix_tb
// self-checking bench for the look-at view matrix block
// ---------------------------------------------------------------------------
//  camera items go in as bursts with random gaps, and the result side
//  stalls on a rotating pattern of its own. a bit-exact model of the
//  camera frame works out the four expected rows for each item taken.
//  each row that leaves the block is compared field by field with the
//  oldest expectation. the up vector is rewritten between phases while
//  the block is idle, and covers reset, zero and extreme settings.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module look_at_view_matrix_tb;
   import lav_pkg::*;

   localparam int DW    = 32;
   localparam int FRAC  = 16;
   localparam int REQ_W = 192;
   localparam int RSP_W = 136;

   typedef logic signed [127:0] wide_t;
   typedef logic signed [DW-1:0] fix_t;

   typedef struct {
      logic [1:0] row;
      fix_t       col [4];
      logic       last;
      logic       degen;
   } matrix_row_t;

   class lav_scoreboard;
      matrix_row_t rows_due [$];
      fix_t        up [3];
      int          errors;
      int          rows_seen;
      int          items_seen;

      function new();
         up[0] = 0;
         up[1] = fix_t'(1 << FRAC);
         up[2] = 0;
      endfunction

      function int pending();
         return rows_due.size();
      endfunction

      function wide_t sat(wide_t x);
         wide_t hi, lo;
         hi = (wide_t'(1) <<< (DW - 1)) - 1;
         lo = -(wide_t'(1) <<< (DW - 1));
         if (x > hi) return hi;
         if (x < lo) return lo;
         return x;
      endfunction

      function wide_t round_away(wide_t x, int k);
         wide_t m;
         m = (x < 0) ? -x : x;
         m = (m + (wide_t'(1) <<< (k - 1))) >>> k;
         return (x < 0) ? -m : m;
      endfunction

      function bit [63:0] root_floor(bit [63:0] x);
         bit [63:0] r, b;
         r = 0;
         b = 64'd1 << 62;
         while (b > x) b = b >> 2;
         while (b != 0) begin
            if (x >= r + b) begin
               x = x - (r + b);
               r = (r >> 1) + b;
            end else begin
               r = r >> 1;
            end
            b = b >> 2;
         end
         return r;
      endfunction

      // unit vector in q2.30, zero and 0 returned for a zero-length vector
      function bit unit_vec(input wide_t v [3], output longint o [3]);
         wide_t     a [3];
         bit [63:0] m [3];
         bit [63:0] sum, s, q;
         int        len;
         len = 0;
         sum = 0;
         for (int i = 0; i < 3; i++) begin
            a[i] = (v[i] < 0) ? -v[i] : v[i];
            for (int b = 0; b < 128; b++) if (a[i][b] && b + 1 > len) len = b + 1;
         end
         if (len == 0) begin
            o[0] = 0; o[1] = 0; o[2] = 0;
            return 0;
         end
         for (int i = 0; i < 3; i++) begin
            if (len > UNIT_BITS) m[i] = 64'(a[i] >> (len - UNIT_BITS));
            else m[i] = 64'(a[i] << (UNIT_BITS - len));
            sum = sum + m[i] * m[i];
         end
         s = root_floor(sum);
         for (int i = 0; i < 3; i++) begin
            q = ((m[i] << UNIT_BITS) + (s >> 1)) / s;
            o[i] = (v[i] < 0) ? -longint'(q) : longint'(q);
         end
         return 1;
      endfunction

      function bit cross_unit(input longint a [3], input longint b [3],
                              output longint o [3]);
         wide_t c [3];
         c[0] = wide_t'(a[1] * b[2] - a[2] * b[1]);
         c[1] = wide_t'(a[2] * b[0] - a[0] * b[2]);
         c[2] = wide_t'(a[0] * b[1] - a[1] * b[0]);
         return unit_vec(c, o);
      endfunction

      function void note_item(fix_t pos [3], fix_t foc [3]);
         wide_t       p [3], d [3], upv [3];
         longint      w [3], u [3], v [3], upn [3];
         longint      fr [3][3];
         wide_t       acc;
         bit          ok;
         matrix_row_t r;
         for (int i = 0; i < 3; i++) begin
            p[i]   = pos[i];
            d[i]   = p[i] - wide_t'(foc[i]);
            upv[i] = up[i];
         end
         ok = unit_vec(d, w);
         ok = unit_vec(upv, upn) & ok;
         ok = cross_unit(upn, w, u) & ok;
         ok = cross_unit(w, u, v) & ok;
         for (int i = 0; i < 3; i++) begin
            fr[0][i] = u[i]; fr[1][i] = v[i]; fr[2][i] = w[i];
         end
         for (int i = 0; i < 3; i++) begin
            r.row = 2'(i);
            for (int k = 0; k < 3; k++)
               r.col[k] = fix_t'(sat(round_away(wide_t'(fr[k][i]), UNIT_BITS - FRAC)));
            r.col[3] = 0;
            r.last   = 0;
            r.degen  = !ok;
            rows_due.push_back(r);
         end
         r.row = LAST_ROW;
         for (int k = 0; k < 3; k++) begin
            acc = 0;
            for (int i = 0; i < 3; i++) acc = acc + wide_t'(fr[k][i]) * p[i];
            r.col[k] = fix_t'(sat(round_away(-acc, UNIT_BITS)));
         end
         r.col[3] = fix_t'(sat(wide_t'(1) <<< FRAC));
         r.last   = 1;
         r.degen  = !ok;
         rows_due.push_back(r);
         items_seen++;
      endfunction

      function void report(string what, logic [63:0] got, logic [63:0] want);
         errors++;
         $display("mismatch at %0t: %s got %h expected %h", $time, what, got, want);
      endfunction

      function void check(matrix_row_t r);
         matrix_row_t e;
         rows_seen++;
         if (rows_due.size() == 0) begin
            report("unexpected row", r.row, 0);
            return;
         end
         e = rows_due.pop_front();
         if (r.row !== e.row) report("row_index", r.row, e.row);
         for (int k = 0; k < 4; k++)
            if (r.col[k] !== e.col[k]) report($sformatf("row %0d col_%0d", e.row, k),
                                              r.col[k], e.col[k]);
         if (r.last !== e.last) report("last_row", r.last, e.last);
         if (r.degen !== e.degen) report("degenerate", r.degen, e.degen);
      endfunction
   endclass

   logic              clock = 0;
   logic              reset = 1;
   logic              req_tvalid = 0;
   logic              req_tready;
   logic [REQ_W-1:0]  req_tdata = '0;
   logic              rsp_tvalid;
   logic              rsp_tready = 0;
   logic [RSP_W-1:0]  rsp_tdata;
   logic              rsp_tlast;
   logic              rsp_tuser;
   logic              csr_psel = 0;
   logic              csr_penable = 0;
   logic              csr_pwrite = 0;
   logic [3:0]        csr_paddr = '0;
   logic [31:0]       csr_pwdata = '0;
   logic [31:0]       csr_prdata;
   logic              csr_pready;

   lav_scoreboard sb = new();
   int            burst_left = 0;
   int            settings_run = 0;
   int unsigned   cyc = 0;

   look_at_view_matrix dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast), .rsp_tuser(rsp_tuser),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always #4 clock = ~clock;

   initial begin
      #2000000;
      $display("FAIL");
      $finish;
   end

   // result side: check the row taken, then pick the next ready level
   always @(posedge clock) begin
      matrix_row_t r;
      if (reset) begin
         rsp_tready <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            r.row = rsp_tdata[1:0];
            for (int k = 0; k < 4; k++) r.col[k] = rsp_tdata[2 + k*DW +: DW];
            r.last  = rsp_tlast;
            r.degen = rsp_tuser;
            sb.check(r);
         end
         cyc++;
         case ((cyc / 600) % 4)
            0: rsp_tready <= 1;
            1: rsp_tready <= $urandom_range(0, 1);
            2: rsp_tready <= (cyc % 11) < 3;
            default: rsp_tready <= ($urandom_range(0, 9) != 0);
         endcase
      end
   end

   task automatic csr_write(reg_index_type idx, fix_t value);
      csr_psel    <= 1;
      csr_penable <= 0;
      csr_pwrite  <= 1;
      csr_paddr   <= 4'(idx) << 2;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      csr_psel    <= 0;
      csr_penable <= 0;
      csr_pwrite  <= 0;
      sb.up[idx] = value;
   endtask

   task automatic set_up(fix_t x, fix_t y, fix_t z);
      csr_write(REG_UP_X, x);
      csr_write(REG_UP_Y, y);
      csr_write(REG_UP_Z, z);
      settings_run++;
   endtask

   task automatic send_item(fix_t px, fix_t py, fix_t pz, fix_t fx, fix_t fy, fix_t fz);
      fix_t pos [3], foc [3];
      int   gap;
      pos[0] = px; pos[1] = py; pos[2] = pz;
      foc[0] = fx; foc[1] = fy; foc[2] = fz;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 30) : $urandom_range(0, 3);
         if (gap > 0) begin
            req_tvalid <= 0;
            repeat (gap) @(posedge clock);
         end
      end
      req_tvalid <= 1;
      req_tdata  <= {fz, fy, fx, pz, py, px};
      do @(posedge clock); while (!req_tready);
      sb.note_item(pos, foc);
      burst_left--;
   endtask

   task automatic drain();
      req_tvalid <= 0;
      while (sb.pending() > 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   function automatic fix_t pick_value();
      case ($urandom_range(0, 9))
         0, 1, 2: return $urandom;
         3: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
         default: return fix_t'($signed($urandom_range(0, 1 << 24)) - (1 << 23));
      endcase
   endfunction

   task automatic random_items(int n);
      fix_t px, py, pz;
      for (int i = 0; i < n; i++) begin
         px = pick_value(); py = pick_value(); pz = pick_value();
         case ($urandom_range(0, 19))
            0: send_item(px, py, pz, px, py, pz);
            1: send_item(px, py, pz, px - sb.up[0], py - sb.up[1], pz - sb.up[2]);
            default: send_item(px, py, pz, pick_value(), pick_value(), pick_value());
         endcase
      end
   endtask

   localparam fix_t MAXV = 32'h7fffffff;
   localparam fix_t MINV = 32'h80000000;
   localparam fix_t ONE  = 32'h00010000;

   initial begin
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // reset up vector, directed corners
      settings_run = 1;
      send_item(0, 0, ONE, 0, 0, 0);
      send_item(0, 0, 0, 0, 0, 0);
      send_item(MAXV, MAXV, MAXV, MINV, MINV, MINV);
      send_item(MINV, MINV, MINV, MAXV, MAXV, MAXV);
      send_item(MAXV, MINV, MAXV, MINV, MAXV, MINV);
      send_item(0, 5 * ONE, 0, 0, 0, 0);
      send_item(0, MINV, 0, 0, MAXV, 0);
      send_item(1, 0, 0, 0, 0, 0);
      send_item(0, 0, 1, 0, 0, -1);
      send_item(3 * ONE, 2 * ONE, 7 * ONE, -ONE, ONE, 0);
      send_item(MAXV, 0, 0, MAXV, 0, 0);
      send_item(32'h12345678, 32'h9abcdef0, 32'h0f0f0f0f, 0, 0, 0);
      random_items(30);
      drain();
      random_items(40);
      drain();

      set_up(0, 0, 0);
      send_item(ONE, 2 * ONE, 3 * ONE, 0, 0, 0);
      random_items(30);
      drain();

      set_up(MAXV, MAXV, MAXV);
      send_item(ONE, ONE, ONE, 0, 0, 0);
      random_items(70);
      drain();

      set_up(MINV, MINV, MINV);
      random_items(70);
      drain();

      set_up(MINV, 0, MAXV);
      random_items(60);
      drain();

      set_up(1, 0, 0);
      random_items(50);
      drain();

      set_up($urandom, $urandom, $urandom);
      random_items(60);
      drain();

      set_up(0, -ONE, 0);
      random_items(60);
      drain();
      repeat (300) @(posedge clock);

      $display("%0d camera items over %0d up vector settings, %0d rows checked",
               sb.items_seen, settings_run, sb.rows_seen);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
